/* src/rxwp_pkg.sv */
// ---------------------------------------------------------------------------
// rxwp_pkg
// Shared types and constants for the Ethernet receive filter and word packer.
// ---------------------------------------------------------------------------
`default_nettype none

package rxwp_pkg;

    localparam int          MAX_FRAME_DEFAULT = 1024;
    localparam logic [47:0] STATION_RESET     = 48'h01606E11020F;

    localparam logic [7:0]  BCAST_BYTE    = 8'hFF;
    localparam logic [7:0]  ETYPE_HI      = 8'h08;
    localparam logic [7:0]  ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0]  ETYPE_ARP_LO  = 8'h06;
    localparam logic [15:0] HDR_LEN       = 16'd14;
    localparam logic [2:0]  ARP_WORDS     = 3'd7;

    localparam logic KIND_ARP  = 1'b0;
    localparam logic KIND_IPV4 = 1'b1;

    typedef enum logic [1:0] {
        CLASS_UNDECIDED,
        CLASS_ARP,
        CLASS_IPV4,
        CLASS_DROP
    } frame_class_t;

    // Result descriptor: first word plus a count; words after the first are zero.
    typedef struct packed {
        logic [31:0] word;
        logic        kind;
        logic        last;
        logic        trunc;
        logic [2:0]  count;
    } word_desc_t;

endpackage

`default_nettype wire

/* src/rxwp_intf.sv */
// ---------------------------------------------------------------------------
// rxwp_intf
// Valid/ready channel interfaces: receive bytes, packed words, configuration.
// ---------------------------------------------------------------------------
`default_nettype none

interface rxwp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, rx_byte, end_of_frame, input ready);
    modport sink   (input valid, rx_byte, end_of_frame, output ready);
endinterface

interface rxwp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] payload_word;
    logic        word_kind;
    logic        last_word;
    logic        truncated;

    modport source (output valid, payload_word, word_kind, last_word, truncated,
                    input ready);
    modport sink   (input valid, payload_word, word_kind, last_word, truncated,
                    output ready);
endinterface

interface rxwp_cfg_if;
    logic        valid;
    logic        ready;
    logic [47:0] station_address;

    modport source (output valid, station_address, input ready);
    modport sink   (input valid, station_address, output ready);
endinterface

`default_nettype wire

/* src/rxwp_frame_parser.sv */
// ---------------------------------------------------------------------------
// rxwp_frame_parser
// Input register, address filter, EtherType classifier and payload packer.
// Produces at most one result descriptor per accepted byte.
// ---------------------------------------------------------------------------
`default_nettype none

module rxwp_frame_parser #(
    parameter int MAX_FRAME = rxwp_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    rxwp_byte_if.sink           rx,
    rxwp_cfg_if.sink            cfg,
    output rxwp_pkg::word_desc_t desc,
    output logic                desc_valid,
    input  logic                desc_ready
);
    import rxwp_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME + 1);

    logic [47:0]      station_reg;
    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             eof_reg;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             bm_reg, bm_next;
    logic             sm_reg, sm_next;
    frame_class_t     class_reg, class_next;
    logic [15:0]      len_reg, len_next;
    logic [23:0]      part_reg, part_next;
    logic [2:0]       arp_reg, arp_next;
    logic             fin_reg, fin_next;

    logic             take;
    logic             active;
    logic [15:0]      idx16;
    logic [15:0]      p;
    logic [1:0]       pos;
    logic [7:0]       mine;
    logic [31:0]      w_b;
    logic [23:0]      part_or;
    logic             emit_b;
    logic [31:0]      word_b;
    logic             last_b;
    logic             fire;
    word_desc_t       desc_c;

    assign take   = idx_reg < IDX_W'(MAX_FRAME);
    assign active = take && (class_reg != CLASS_DROP) && !fin_reg;
    assign idx16  = 16'(idx_reg);
    assign p      = idx16 - HDR_LEN;
    assign pos    = p[1:0];

    always_comb
    begin
        case (idx_reg[2:0])
            3'd0:    mine = station_reg[47:40];
            3'd1:    mine = station_reg[39:32];
            3'd2:    mine = station_reg[31:24];
            3'd3:    mine = station_reg[23:16];
            3'd4:    mine = station_reg[15:8];
            default: mine = station_reg[7:0];
        endcase
        case (pos)
            2'd0:    begin w_b = {part_reg, 8'h00} | {byte_reg, 24'h0};
                           part_or = {byte_reg, 16'h0}; end
            2'd1:    begin w_b = {part_reg, 8'h00} | {8'h0, byte_reg, 16'h0};
                           part_or = {8'h0, byte_reg, 8'h0}; end
            2'd2:    begin w_b = {part_reg, 8'h00} | {16'h0, byte_reg, 8'h0};
                           part_or = {16'h0, byte_reg}; end
            default: begin w_b = {part_reg, 8'h00} | {24'h0, byte_reg};
                           part_or = 24'h0; end
        endcase
    end

    always_comb
    begin
        idx_next   = take ? idx_reg + IDX_W'(1) : idx_reg;
        bm_next    = bm_reg;
        sm_next    = sm_reg;
        class_next = class_reg;
        len_next   = len_reg;
        part_next  = part_reg;
        arp_next   = arp_reg;
        fin_next   = fin_reg;
        emit_b     = 1'b0;
        word_b     = w_b;
        last_b     = 1'b0;

        if (active)
        begin
            if (idx16 < 16'd6)
            begin
                bm_next = bm_reg && (byte_reg == BCAST_BYTE);
                sm_next = sm_reg && (byte_reg == mine);
                if (idx16 == 16'd5 && !bm_next && !sm_next)
                    class_next = CLASS_DROP;
            end
            else if (idx16 == 16'd12)
            begin
                part_next = {16'h0, byte_reg};
            end
            else if (idx16 == 16'd13)
            begin
                if (part_reg == {16'h0, ETYPE_HI} && byte_reg == ETYPE_IPV4_LO)
                    class_next = CLASS_IPV4;
                else if (part_reg == {16'h0, ETYPE_HI} && byte_reg == ETYPE_ARP_LO)
                    class_next = CLASS_ARP;
                else
                    class_next = CLASS_DROP;
                part_next = 24'h0;
            end
            else if (idx16 >= HDR_LEN)
            begin
                if (class_reg == CLASS_ARP)
                begin
                    if (pos == 2'd3)
                    begin
                        part_next = 24'h0;
                        arp_next  = arp_reg + 3'd1;
                        fin_next  = (arp_next == ARP_WORDS);
                        emit_b    = 1'b1;
                        last_b    = fin_next;
                    end
                    else
                    begin
                        part_next = part_reg | part_or;
                    end
                end
                else
                begin
                    if (p == 16'd2)
                        len_next[15:8] = byte_reg;
                    if (p == 16'd3)
                        len_next[7:0] = byte_reg;

                    if (p == 16'd3)
                    begin
                        part_next = 24'h0;
                        if (len_next == 16'd0)
                        begin
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            if (len_next < 16'd4)
                            begin
                                case (len_next[1:0])
                                    2'd1:    word_b = w_b & 32'hFF000000;
                                    2'd2:    word_b = w_b & 32'hFFFF0000;
                                    default: word_b = w_b & 32'hFFFFFF00;
                                endcase
                            end
                            fin_next = (len_next <= 16'd4);
                            emit_b   = 1'b1;
                            last_b   = fin_next;
                        end
                    end
                    else if (p > 16'd3 && (pos == 2'd3 || p + 16'd1 == len_reg))
                    begin
                        part_next = 24'h0;
                        fin_next  = (p + 16'd1 == len_reg);
                        emit_b    = 1'b1;
                        last_b    = fin_next;
                    end
                    else
                    begin
                        part_next = part_reg | part_or;
                    end
                end
            end
        end

        desc_c.word  = word_b;
        desc_c.kind  = (class_reg == CLASS_ARP) ? KIND_ARP : KIND_IPV4;
        desc_c.last  = last_b;
        desc_c.trunc = 1'b0;
        desc_c.count = emit_b ? 3'd1 : 3'd0;

        if (eof_reg)
        begin
            if (class_next == CLASS_ARP && !fin_next)
            begin
                desc_c.kind  = KIND_ARP;
                desc_c.last  = 1'b1;
                desc_c.count = (ARP_WORDS - arp_next) + (emit_b ? 3'd1 : 3'd0);
                if (!emit_b)
                    desc_c.word = {part_next, 8'h00};
            end
            else if (class_next == CLASS_IPV4 && !fin_next)
            begin
                desc_c.kind  = KIND_IPV4;
                desc_c.last  = 1'b1;
                desc_c.trunc = 1'b1;
                desc_c.count = 3'd1;
                if (!emit_b)
                    desc_c.word = {part_next, 8'h00};
            end
        end
    end

    assign desc       = desc_c;
    assign desc_valid = in_valid_reg && (desc_c.count != 3'd0);
    assign fire       = in_valid_reg && (!desc_valid || desc_ready);
    assign rx.ready   = !in_valid_reg || fire;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
            eof_reg  <= rx.end_of_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg  <= STATION_RESET;
            in_valid_reg <= 1'b0;
            idx_reg      <= '0;
            bm_reg       <= 1'b1;
            sm_reg       <= 1'b1;
            class_reg    <= CLASS_UNDECIDED;
            len_reg      <= 16'h0;
            part_reg     <= 24'h0;
            arp_reg      <= 3'd0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                station_reg <= cfg.station_address;
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (fire)
            begin
                if (eof_reg)
                begin
                    idx_reg   <= '0;
                    bm_reg    <= 1'b1;
                    sm_reg    <= 1'b1;
                    class_reg <= CLASS_UNDECIDED;
                    len_reg   <= 16'h0;
                    part_reg  <= 24'h0;
                    arp_reg   <= 3'd0;
                    fin_reg   <= 1'b0;
                end
                else
                begin
                    idx_reg   <= idx_next;
                    bm_reg    <= bm_next;
                    sm_reg    <= sm_next;
                    class_reg <= class_next;
                    len_reg   <= len_next;
                    part_reg  <= part_next;
                    arp_reg   <= arp_next;
                    fin_reg   <= fin_next;
                end
            end
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(MAX_FRAME))
        else $error("byte index past frame limit");

    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && class_reg == CLASS_DROP) |-> !desc_valid)
        else $error("dropped frame produced a word");

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eof_reg) |=> (idx_reg == '0 && class_reg == CLASS_UNDECIDED))
        else $error("frame state not cleared at end of frame");

endmodule

`default_nettype wire

/* src/rxwp_word_out.sv */
// ---------------------------------------------------------------------------
// rxwp_word_out
// Result register; replays zero words for an ARP frame that ended early.
// ---------------------------------------------------------------------------
`default_nettype none

module rxwp_word_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rxwp_pkg::word_desc_t desc,
    input  logic                 desc_valid,
    output logic                 desc_ready,
    rxwp_word_if.source          words
);
    import rxwp_pkg::*;

    logic        valid_reg;
    logic [2:0]  remain_reg;
    logic [31:0] word_reg;
    logic        kind_reg;
    logic        last_reg;
    logic        trunc_reg;
    logic        load_ok;
    logic        advance;

    assign load_ok    = !valid_reg || (words.ready && remain_reg == 3'd0);
    assign advance    = valid_reg && words.ready && remain_reg != 3'd0;
    assign desc_ready = load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            remain_reg <= 3'd0;
        end
        else if (load_ok)
        begin
            valid_reg <= desc_valid;
            if (desc_valid)
                remain_reg <= desc.count - 3'd1;
        end
        else if (advance)
        begin
            remain_reg <= remain_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && desc_valid)
        begin
            word_reg  <= desc.word;
            kind_reg  <= desc.kind;
            last_reg  <= desc.last;
            trunc_reg <= desc.trunc;
        end
        else if (advance)
        begin
            word_reg <= 32'h0;
        end
    end

    assign words.valid        = valid_reg;
    assign words.payload_word = word_reg;
    assign words.word_kind    = kind_reg;
    assign words.last_word    = last_reg && (remain_reg == 3'd0);
    assign words.truncated    = trunc_reg;

    a_remain_valid: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg != 3'd0 |-> valid_reg)
        else $error("pending words without a valid word");

    a_not_last_early: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && remain_reg != 3'd0) |-> !words.last_word)
        else $error("last flag before final word");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (valid_reg && word_reg == 32'h0))
        else $error("padding word not zero");

endmodule

`default_nettype wire

/* src/eth_rx_filter_word_packer_top.sv */
// ---------------------------------------------------------------------------
// eth_rx_filter_word_packer_top
// Ethernet receive address filter, EtherType classifier and word packer.
// ---------------------------------------------------------------------------
// Takes one frame byte per clock while the word output is ready and no ARP
// padding drains. Each byte passes an input register, the filter/packer logic
// and a result register. Apart from back-pressure on the word output, the only
// stall is an ARP frame that ends before byte 42: its end-of-frame byte yields
// up to seven words, sent one per cycle from the result register while the
// output is ready, and the input waits while they drain. Frames not addressed
// to broadcast or the station address, and EtherTypes other than IPv4 and ARP,
// produce no words. The station address may only be written while idle.
`default_nettype none

module eth_rx_filter_word_packer_top #(
    parameter int MAX_FRAME = rxwp_pkg::MAX_FRAME_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    rxwp_byte_if.sink    rx,
    rxwp_word_if.source  words,
    rxwp_cfg_if.sink     cfg
);
    import rxwp_pkg::*;

    word_desc_t desc;
    logic       desc_valid;
    logic       desc_ready;

    rxwp_frame_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg        (cfg),
        .desc       (desc),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready)
    );

    rxwp_word_out u_word_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .words      (words)
    );

endmodule

`default_nettype wire

/* test/tb_eth_rx_filter_word_packer_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_eth_rx_filter_word_packer_top
// Self-checking bench for the receive filter and word packer. A directed table
// of frames covers address match and miss, every EtherType class, length
// corner cases, early frame ends and the byte index cap. Random frames follow under
// several station addresses. Each word is checked against an in-bench model of the
// filter and packer or its row's exp_n, with random idle bursts on both channels.
// ---------------------------------------------------------------------------

module tb_eth_rx_filter_word_packer_top;
    import rxwp_pkg::*;

    localparam int          FRAME_CAP     = MAX_FRAME_DEFAULT;
    localparam logic [15:0] ETYPE_IPV4    = {ETYPE_HI, ETYPE_IPV4_LO};
    localparam logic [15:0] ETYPE_ARP     = {ETYPE_HI, ETYPE_ARP_LO};
    localparam int          ARP_END       = int'(HDR_LEN) + 4 * int'(ARP_WORDS);
    localparam int          DRAIN_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASE_BYTES   = 65;
    localparam int          MIN_WORDS     = 48;

    localparam int DST_BCAST   = 0;
    localparam int DST_STATION = 1;
    localparam int DST_NEAR    = 2;
    localparam int DST_OTHER   = 3;

    localparam int FILL_RAMP   = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int FILL_RANDOM = 3;

    localparam int PREDICTED = -1;

    typedef struct packed {
        logic [31:0] word;
        logic        kind;
        logic        last;
        logic        trunc;
    } word_rec_t;

    typedef struct packed {
        int          dst;
        logic [15:0] etype;
        logic [15:0] ip_len;
        int          nbytes;
        int          fill;
        int          exp_n;
        logic        exp_kind;
        logic        exp_trunc;
    } frame_row_t;

    // exp_n >= 0: that many words, first..last all zero, last flagged on the final one
    localparam frame_row_t DIRECTED [24] = '{
        '{DST_BCAST,   ETYPE_IPV4, 16'd0,     20,   FILL_RAMP,   0,         KIND_IPV4, 1'b0},
        '{DST_STATION, ETYPE_IPV4, 16'd8,     22,   FILL_RAMP,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'd1,     24,   FILL_ONES,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_STATION, ETYPE_IPV4, 16'd3,     18,   FILL_RAMP,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'd5,     19,   FILL_RANDOM, PREDICTED, KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'hFFFF,  30,   FILL_ONES,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'd12,    22,   FILL_RAMP,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_STATION, ETYPE_IPV4, 16'd20,    14,   FILL_RAMP,   1,         KIND_IPV4, 1'b1},
        '{DST_BCAST,   ETYPE_IPV4, 16'h1234,  17,   FILL_RAMP,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'd40,    15,   FILL_ZERO,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'd2,     16,   FILL_ZERO,   PREDICTED, KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_ARP,  16'd0,     60,   FILL_RAMP,   PREDICTED, KIND_ARP,  1'b0},
        '{DST_STATION, ETYPE_ARP,  16'hFFFF,  42,   FILL_ONES,   PREDICTED, KIND_ARP,  1'b0},
        '{DST_BCAST,   ETYPE_ARP,  16'd0,     14,   FILL_RAMP,   7,         KIND_ARP,  1'b0},
        '{DST_STATION, ETYPE_ARP,  16'd0,     21,   FILL_RANDOM, PREDICTED, KIND_ARP,  1'b0},
        '{DST_OTHER,   ETYPE_IPV4, 16'd8,     30,   FILL_RAMP,   0,         KIND_IPV4, 1'b0},
        '{DST_NEAR,    ETYPE_ARP,  16'd0,     50,   FILL_RAMP,   0,         KIND_ARP,  1'b0},
        '{DST_BCAST,   16'h86DD,   16'd8,     30,   FILL_RAMP,   0,         KIND_IPV4, 1'b0},
        '{DST_STATION, 16'h0807,   16'd8,     30,   FILL_RAMP,   0,         KIND_IPV4, 1'b0},
        '{DST_BCAST,   16'h0006,   16'd8,     30,   FILL_RAMP,   0,         KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'd8,     10,   FILL_RAMP,   0,         KIND_IPV4, 1'b0},
        '{DST_STATION, ETYPE_IPV4, 16'd8,     1,    FILL_RAMP,   0,         KIND_IPV4, 1'b0},
        '{DST_BCAST,   ETYPE_IPV4, 16'hFFFF,  1100, FILL_RANDOM, PREDICTED, KIND_IPV4, 1'b0},
        '{DST_STATION, ETYPE_IPV4, 16'd1010,  1100, FILL_RAMP,   PREDICTED, KIND_IPV4, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    rxwp_byte_if rx();
    rxwp_word_if words();
    rxwp_cfg_if  cfg();

    eth_rx_filter_word_packer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .words (words),
        .cfg   (cfg)
    );

    always #1 clk = ~clk;

    // model state
    logic [47:0]  my_station;
    int unsigned  frame_pos;
    bit           bcast_hit;
    bit           station_hit;
    frame_class_t frame_cls;
    logic [15:0]  ip_len;
    logic [23:0]  pend_bytes;
    int unsigned  arp_sent;
    bit           frame_done;

    word_rec_t  words_due[$];
    word_rec_t  step_words[$];
    logic [7:0] frame_q[$];

    int typed_n = PREDICTED;
    logic typed_kind;
    logic typed_trunc;
    int idle_level = 0;
    bit idle_on = 1'b1;
    int stall_left = 0;

    int err_count = 0;
    int frames_sent = 0;
    int useful_bytes = 0;
    int words_checked = 0;
    int words_predicted = 0;
    int trunc_seen = 0;
    int arp_frames = 0;
    int ipv4_frames = 0;
    int dropped_frames = 0;

    function automatic void clear_frame_state();
        frame_pos   = 0;
        bcast_hit   = 1'b1;
        station_hit = 1'b1;
        frame_cls   = CLASS_UNDECIDED;
        ip_len      = '0;
        pend_bytes  = '0;
        arp_sent    = 0;
        frame_done  = 1'b0;
    endfunction

    function automatic void pack_payload(int unsigned p, logic [7:0] b);
        int lane;
        logic [31:0] w;
        lane = int'(p % 4);
        w = {pend_bytes, 8'h00} | ({24'h0, b} << (24 - 8 * lane));
        if (frame_cls == CLASS_ARP) begin
            if (lane == 3) begin
                pend_bytes = '0;
                arp_sent++;
                if (arp_sent >= ARP_WORDS)
                    frame_done = 1'b1;
                step_words.push_back('{w, KIND_ARP, frame_done, 1'b0});
            end
            else
                pend_bytes = pend_bytes | ({16'h0, b} << (16 - 8 * lane));
            return;
        end
        if (p == 2)
            ip_len[15:8] = b;
        if (p == 3)
            ip_len[7:0] = b;
        if (p == 3) begin
            pend_bytes = '0;
            if (ip_len == 0) begin
                frame_done = 1'b1;
                return;
            end
            if (ip_len < 4)
                w &= ~(32'hFFFF_FFFF >> (8 * ip_len));
            if (ip_len <= 4)
                frame_done = 1'b1;
            step_words.push_back('{w, KIND_IPV4, frame_done, 1'b0});
        end
        else if (p > 3 && (lane == 3 || p + 1 == ip_len)) begin
            pend_bytes = '0;
            if (p + 1 == ip_len)
                frame_done = 1'b1;
            step_words.push_back('{w, KIND_IPV4, frame_done, 1'b0});
        end
        else
            pend_bytes = pend_bytes | ({16'h0, b} << (16 - 8 * lane));
    endfunction

    function automatic void filter_byte(int unsigned i, logic [7:0] b);
        if (frame_cls == CLASS_DROP || frame_done)
            return;
        if (i < 6) begin
            if (b != BCAST_BYTE)
                bcast_hit = 1'b0;
            if (b != my_station[47 - 8 * i -: 8])
                station_hit = 1'b0;
            if (i == 5 && !bcast_hit && !station_hit)
                frame_cls = CLASS_DROP;
        end
        else if (i == 12)
            pend_bytes = {16'h0, b};
        else if (i == 13) begin
            if (pend_bytes == {16'h0, ETYPE_HI} && b == ETYPE_IPV4_LO)
                frame_cls = CLASS_IPV4;
            else if (pend_bytes == {16'h0, ETYPE_HI} && b == ETYPE_ARP_LO)
                frame_cls = CLASS_ARP;
            else
                frame_cls = CLASS_DROP;
            pend_bytes = '0;
        end
        else if (i >= HDR_LEN)
            pack_payload(i - int'(HDR_LEN), b);
    endfunction

    function automatic void close_frame();
        logic [31:0] w;
        if (frame_cls == CLASS_ARP && !frame_done) begin
            w = {pend_bytes, 8'h00};
            while (arp_sent < ARP_WORDS) begin
                arp_sent++;
                step_words.push_back('{w, KIND_ARP, arp_sent >= ARP_WORDS, 1'b0});
                w = '0;
            end
        end
        else if (frame_cls == CLASS_IPV4 && !frame_done) begin
            if (step_words.size() > 0) begin
                step_words[step_words.size() - 1].last  = 1'b1;
                step_words[step_words.size() - 1].trunc = 1'b1;
            end
            else
                step_words.push_back('{{pend_bytes, 8'h00}, KIND_IPV4, 1'b1, 1'b1});
        end
        case (frame_cls)
            CLASS_ARP:  arp_frames++;
            CLASS_IPV4: ipv4_frames++;
            default:    dropped_frames++;
        endcase
    endfunction

    // one accepted byte: returns 1 when the byte is not ignored
    function automatic bit step_byte(logic [7:0] b, logic eof);
        bit took;
        took = 1'b0;
        if (frame_pos < FRAME_CAP) begin
            took = frame_cls != CLASS_DROP && !frame_done;
            frame_pos++;
            filter_byte(frame_pos - 1, b);
        end
        if (eof) begin
            close_frame();
            clear_frame_state();
        end
        return took;
    endfunction

    function automatic void take_in(logic [7:0] b, logic eof);
        int k;
        step_words.delete();
        if (step_byte(b, eof))
            useful_bytes++;
        if (typed_n < 0) begin
            foreach (step_words[j])
                words_due.push_back(step_words[j]);
            words_predicted += step_words.size();
        end
        else if (eof) begin
            for (k = 0; k < typed_n; k++)
                words_due.push_back('{32'h0, typed_kind, k == typed_n - 1,
                                      k == typed_n - 1 && typed_trunc});
            words_predicted += typed_n;
        end
    endfunction

    task automatic check_word();
        word_rec_t e;
        if (words_due.size() == 0) begin
            $error("unexpected word %h kind %b last %b trunc %b", words.payload_word,
                   words.word_kind, words.last_word, words.truncated);
            err_count++;
            return;
        end
        e = words_due.pop_front();
        words_checked++;
        if (words.truncated === 1'b1)
            trunc_seen++;
        if (words.payload_word !== e.word) begin
            $error("payload_word: expected %h, got %h", e.word, words.payload_word);
            err_count++;
        end
        if (words.word_kind !== e.kind) begin
            $error("word_kind: expected %b, got %b", e.kind, words.word_kind);
            err_count++;
        end
        if (words.last_word !== e.last) begin
            $error("last_word: expected %b, got %b", e.last, words.last_word);
            err_count++;
        end
        if (words.truncated !== e.trunc) begin
            $error("truncated: expected %b, got %b", e.trunc, words.truncated);
            err_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (words.valid && words.ready)
                check_word();
            if (stall_left > 0) begin
                stall_left--;
                words.ready <= 1'b0;
            end
            else if (idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
                stall_left = $urandom_range(0, 14);
                words.ready <= 1'b0;
            end
            else
                words.ready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic eof);
        int n;
        if (idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
            n = $urandom_range(1, 15);
            rx.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        rx.valid        <= 1'b1;
        rx.rx_byte      <= b;
        rx.end_of_frame <= eof;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        take_in(b, eof);
    endtask

    task automatic send_frame();
        int k;
        idle_level = idle_on ? $urandom_range(0, 3) : 0;
        for (k = 0; k < frame_q.size(); k++)
            send_byte(frame_q[k], k == frame_q.size() - 1);
        frames_sent++;
    endtask

    function automatic void build_frame(logic [47:0] da, logic [15:0] etype,
                                        logic [15:0] len, int nbytes, int fill);
        int k;
        logic [7:0] v;
        frame_q.delete();
        for (k = 0; k < nbytes; k++) begin
            if (k < 6)
                v = da[47 - 8 * k -: 8];
            else if (k == 12)
                v = etype[15:8];
            else if (k == 13)
                v = etype[7:0];
            else if (k == 16)
                v = len[15:8];
            else if (k == 17)
                v = len[7:0];
            else case (fill)
                FILL_RAMP: v = 8'(k);
                FILL_ZERO: v = 8'h00;
                FILL_ONES: v = 8'hFF;
                default:   v = 8'($urandom);
            endcase
            frame_q.push_back(v);
        end
    endfunction

    function automatic logic [47:0] dest_for(int dst);
        logic [47:0] da;
        int k;
        da = my_station;
        case (dst)
            DST_BCAST: da = '1;
            DST_OTHER: da = ~my_station;
            DST_NEAR:
            begin
                k = $urandom_range(0, 5);
                da[8 * k +: 8] = da[8 * k +: 8] ^ 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
        return da;
    endfunction

    task automatic random_frame();
        logic [47:0] da;
        logic [15:0] etype;
        logic [15:0] len;
        int nominal;
        int nbytes;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            da = dest_for(DST_BCAST);
        else if (r < 8)
            da = dest_for(DST_STATION);
        else if (r == 8)
            da = dest_for(DST_NEAR);
        else
            da = {16'($urandom), 32'($urandom)};
        r = $urandom_range(0, 11);
        if (r < 6)
            etype = ETYPE_IPV4;
        else if (r < 9)
            etype = ETYPE_ARP;
        else if (r == 9)
            etype = 16'($urandom);
        else if (r == 10)
            etype = {ETYPE_HI, 8'($urandom)};
        else
            etype = {8'($urandom), ETYPE_IPV4_LO};
        r = $urandom_range(0, 9);
        if (r < 8)
            len = 16'($urandom_range(0, 16));
        else if (r == 8)
            len = 16'($urandom_range(17, 48));
        else
            len = 16'($urandom);
        nominal = (etype == ETYPE_ARP) ? ARP_END : int'(HDR_LEN) + ((len > 48) ? 48 : int'(len));
        r = $urandom_range(0, 9);
        if (r < 6)
            nbytes = nominal + $urandom_range(0, 3);
        else if (r < 9)
            nbytes = $urandom_range(1, nominal);
        else
            nbytes = $urandom_range(1, 13);
        build_frame(da, etype, len, nbytes, FILL_RANDOM);
        send_frame();
    endtask

    task automatic drain_words();
        int waited;
        rx.valid <= 1'b0;
        waited = 0;
        while (words_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (words_due.size() != 0) begin
            $error("%0d expected words never arrived", words_due.size());
            err_count++;
            words_due.delete();
        end
    endtask

    task automatic write_station(logic [47:0] v);
        drain_words();
        cfg.valid           <= 1'b1;
        cfg.station_address <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid  <= 1'b0;
        my_station = v;
    endtask

    initial begin
        logic [47:0] station_plan [4];
        int ph;
        int phase_start;
        rst_n               = 1'b0;
        rx.valid            = 1'b0;
        rx.rx_byte          = '0;
        rx.end_of_frame     = 1'b0;
        words.ready         = 1'b0;
        cfg.valid           = 1'b0;
        cfg.station_address = '0;
        my_station          = STATION_RESET;
        clear_frame_state();
        station_plan = '{48'h0, 48'hFFFF_FFFF_FFFF,
                         {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)}};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[r]) begin
            build_frame(dest_for(DIRECTED[r].dst), DIRECTED[r].etype, DIRECTED[r].ip_len,
                        DIRECTED[r].nbytes, DIRECTED[r].fill);
            typed_n     = DIRECTED[r].exp_n;
            typed_kind  = DIRECTED[r].exp_kind;
            typed_trunc = DIRECTED[r].exp_trunc;
            send_frame();
        end
        typed_n = PREDICTED;

        for (ph = 0; ph < 4; ph++) begin
            write_station(station_plan[ph]);
            if (ph == 3)
                idle_on = 1'b0;
            phase_start = useful_bytes;
            while (useful_bytes - phase_start < PHASE_BYTES ||
                   (ph == 3 && words_predicted < MIN_WORDS + 300))
                random_frame();
        end

        idle_level = 0;
        drain_words();

        $display("frames %0d (arp %0d, ipv4 %0d, dropped %0d), live bytes %0d",
                 frames_sent, arp_frames, ipv4_frames, dropped_frames, useful_bytes);
        $display("words checked %0d (%0d truncated), station settings 5", words_checked,
                 trunc_seen);
        if (err_count == 0)
            $display("tb_eth_rx_filter_word_packer_top: done, clean");
        else
            $display("tb_eth_rx_filter_word_packer_top: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_eth_rx_filter_word_packer_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
src/rxwp_pkg.sv
src/rxwp_intf.sv
src/rxwp_frame_parser.sv
src/rxwp_word_out.sv
src/eth_rx_filter_word_packer_top.sv
test/tb_eth_rx_filter_word_packer_top.sv
